// File: hw/rtl/ctl_pkg.sv
// shared definitions for the c subset token lexer
// token kinds, operator codes, character constants, keyword table and lookup functions
// no dependencies
package ctl_pkg;

  localparam int DEF_MAX_WORD = 16;
  localparam int QUEUE_DEPTH  = 2;

  // token kinds
  localparam logic [2:0] KIND_KEYWORD  = 3'd0;
  localparam logic [2:0] KIND_OPERATOR = 3'd1;
  localparam logic [2:0] KIND_IDENT    = 3'd2;
  localparam logic [2:0] KIND_NUMBER   = 3'd3;
  localparam logic [2:0] KIND_INVALID  = 3'd4;

  // operator codes
  localparam logic [5:0] OP_NONE     = 6'd0;
  localparam logic [5:0] OP_PLUS     = 6'd1;
  localparam logic [5:0] OP_MINUS    = 6'd2;
  localparam logic [5:0] OP_STAR     = 6'd3;
  localparam logic [5:0] OP_SLASH    = 6'd4;
  localparam logic [5:0] OP_PERCENT  = 6'd5;
  localparam logic [5:0] OP_ASSIGN   = 6'd6;
  localparam logic [5:0] OP_LPAREN   = 6'd7;
  localparam logic [5:0] OP_RPAREN   = 6'd8;
  localparam logic [5:0] OP_ADD_EQ   = 6'd9;
  localparam logic [5:0] OP_SUB_EQ   = 6'd10;
  localparam logic [5:0] OP_MUL_EQ   = 6'd11;
  localparam logic [5:0] OP_DIV_EQ   = 6'd12;
  localparam logic [5:0] OP_MOD_EQ   = 6'd13;
  localparam logic [5:0] OP_NOT_EQ   = 6'd14;
  localparam logic [5:0] OP_EQ_EQ    = 6'd15;
  localparam logic [5:0] OP_NOT      = 6'd18;
  localparam logic [5:0] OP_INC      = 6'd19;
  localparam logic [5:0] OP_DEC      = 6'd20;
  localparam logic [5:0] OP_GT       = 6'd21;
  localparam logic [5:0] OP_LT       = 6'd22;
  localparam logic [5:0] OP_GE       = 6'd23;
  localparam logic [5:0] OP_LE       = 6'd24;
  localparam logic [5:0] OP_SEMI     = 6'd25;
  localparam logic [5:0] OP_SHR      = 6'd26;
  localparam logic [5:0] OP_SHL      = 6'd27;
  localparam logic [5:0] OP_HASH     = 6'd28;
  localparam logic [5:0] OP_LBRACKET = 6'd29;
  localparam logic [5:0] OP_RBRACKET = 6'd30;
  localparam logic [5:0] OP_LBRACE   = 6'd31;
  localparam logic [5:0] OP_RBRACE   = 6'd32;
  localparam logic [5:0] OP_COMMA    = 6'd33;

  // character constants
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_US    = "_";
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_UA    = "A";
  localparam logic [7:0] CH_UZ    = "Z";
  localparam logic [7:0] CH_LA    = "a";
  localparam logic [7:0] CH_LZ    = "z";

  // keyword table, each entry right-justified in 72 bits
  localparam int KW_NUM     = 18;
  localparam int KW_MAX_LEN = 9;
  localparam logic [71:0] KW_TEXT [KW_NUM] = '{
    72'("if"), 72'("while"), 72'("do"), 72'("else"), 72'("int"), 72'("for"),
    72'("cin"), 72'("cout"), 72'("include"), 72'("main"), 72'("stdio.h"),
    72'("iostream"), 72'("algorithm"), 72'("return"), 72'("endl"),
    72'("using"), 72'("namespace"), 72'("std")
  };
  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd2, 4'd5, 4'd2, 4'd4, 4'd3, 4'd3, 4'd3, 4'd4, 4'd7, 4'd4, 4'd7,
    4'd8, 4'd9, 4'd6, 4'd4, 4'd5, 4'd9, 4'd3
  };

  // token record width apart from the length field:
  // is_op, op_code, too_long, keyword match vector, digits, ident
  localparam int TOK_FIXED_W = 1 + 6 + 1 + KW_NUM + 1 + 1;

  // character at a position of a keyword, zero past its end
  function automatic logic [7:0] kw_byte(input logic [4:0] idx, input logic [3:0] pos);
    logic [71:0] sh;
    logic [3:0]  back;
    sh   = '0;
    back = '0;
    if (pos < KW_LEN[idx]) begin
      back = KW_LEN[idx] - 4'd1 - pos;
      sh   = KW_TEXT[idx] >> {back, 3'b000};
    end
    return sh[7:0];
  endfunction

  function automatic logic [5:0] single_code(input logic [7:0] c);
    case (c)
      "+":     return OP_PLUS;
      "-":     return OP_MINUS;
      "*":     return OP_STAR;
      "/":     return OP_SLASH;
      "%":     return OP_PERCENT;
      "=":     return OP_ASSIGN;
      "(":     return OP_LPAREN;
      ")":     return OP_RPAREN;
      "!":     return OP_NOT;
      ">":     return OP_GT;
      "<":     return OP_LT;
      ";":     return OP_SEMI;
      "#":     return OP_HASH;
      "[":     return OP_LBRACKET;
      "]":     return OP_RBRACKET;
      "{":     return OP_LBRACE;
      "}":     return OP_RBRACE;
      ",":     return OP_COMMA;
      default: return OP_NONE;
    endcase
  endfunction

  function automatic logic [5:0] pair_code(input logic [7:0] a, input logic [7:0] b);
    logic [5:0] r;
    r = OP_NONE;
    if (b == CH_EQ) begin
      case (a)
        "+":     r = OP_ADD_EQ;
        "-":     r = OP_SUB_EQ;
        "*":     r = OP_MUL_EQ;
        "/":     r = OP_DIV_EQ;
        "%":     r = OP_MOD_EQ;
        "!":     r = OP_NOT_EQ;
        "=":     r = OP_EQ_EQ;
        ">":     r = OP_GE;
        "<":     r = OP_LE;
        default: r = OP_NONE;
      endcase
    end else if (a == b) begin
      case (a)
        "+":     r = OP_INC;
        "-":     r = OP_DEC;
        ">":     r = OP_SHR;
        "<":     r = OP_SHL;
        default: r = OP_NONE;
      endcase
    end
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

endpackage

// File: hw/rtl/c_subset_token_lexer.sv
// top level of the streaming lexer for a small c subset
// instantiates ctl_front, ctl_queue and ctl_back; uses ctl_pkg
//
// The lexer takes one source character per transaction on the push side and
// delivers classified tokens (keyword, operator, identifier, number, invalid
// word) on the pop side, oldest first. Tab and NUL count as space; a space or
// an operator character ends a word; an operator character is held back one
// character so that it can pair into a two-character operator; a double
// slash drops the rest of the line; end_of_line flushes the held operator and
// then the word. Words longer than MAX_WORD keep their first MAX_WORD
// characters, report a saturated length and raise too_long. A character is
// accepted on every cycle in which the queue between the front and back ends
// has room, and a character that causes tokens writes one queue entry. The
// output register hands out one token per cycle while pop is held, so a
// character that causes two tokens holds the result side for both. A token
// is written into a queue slot when its character is taken and is then loaded
// into the output register before it shows on the result ports.
// There is no clearing pass after reset; the block is ready in the first cycle.
module c_subset_token_lexer import ctl_pkg::*; #(
  parameter int MAX_WORD = DEF_MAX_WORD
) (
  input  logic                           clk,
  input  logic                           rst,
  // character side
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     char_code,
  input  logic                           end_of_line,
  // token side
  output logic                           empty,
  input  logic                           pop,
  output logic [2:0]                     token_kind,
  output logic [5:0]                     token_code,
  output logic [$clog2(MAX_WORD+1)-1:0]  token_length,
  output logic                           too_long,
  output logic                           last_of_run
);

  localparam int LW      = $clog2(MAX_WORD + 1);
  localparam int TOK_W   = TOK_FIXED_W + LW;
  // an entry holds two token records and a flag for the second one
  localparam int ENTRY_W = 2 * TOK_W + 1;

  logic               q_write;
  logic               q_read;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;

  // front: character state, pairing and comment handling
  ctl_front #(
    .MAX_WORD (MAX_WORD)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .char_code   (char_code),
    .end_of_line (end_of_line),
    .q_full      (full),
    .q_write     (q_write),
    .q_data      (q_wdata)
  );

  // decoupling queue, its full flag is the push-side back-pressure
  ctl_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_write),
    .wr_data (q_wdata),
    .full    (full),
    .rd_en   (q_read),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // back: keyword lookup, word classification and the output register
  ctl_back #(
    .MAX_WORD (MAX_WORD)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_rdata),
    .q_read       (q_read),
    .empty        (empty),
    .pop          (pop),
    .token_kind   (token_kind),
    .token_code   (token_code),
    .token_length (token_length),
    .too_long     (too_long),
    .last_of_run  (last_of_run)
  );

endmodule

// File: hw/rtl/ctl_front.sv
// front end of the lexer: takes characters, tracks word and separator state
// and writes up to two token records per character into the queue; uses ctl_pkg
module ctl_front import ctl_pkg::*; #(
  parameter int MAX_WORD = DEF_MAX_WORD,
  localparam int LW = $clog2(MAX_WORD + 1),
  localparam int TOK_W = TOK_FIXED_W + LW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [7:0]       char_code,
  input  logic             end_of_line,
  input  logic             q_full,
  output logic             q_write,
  output logic [2*TOK_W:0] q_data
);

  typedef struct packed {
    logic              is_op;
    logic [5:0]        op_code;
    logic [LW-1:0]     len;
    logic              too_long;
    logic [KW_NUM-1:0] match;
    logic              digits;
    logic              ident;
  } tok_t;

  typedef struct packed {
    logic two;
    tok_t t1;
    tok_t t0;
  } entry_t;

  // word summary, kept instead of the characters themselves
  logic [LW-1:0]     count;
  logic              overflow;
  logic [KW_NUM-1:0] match;
  logic              digits;
  logic              ident;
  logic [7:0]        pend_char;
  logic              pend_valid;
  logic              in_comment;

  logic [LW-1:0]     count_next;
  logic              overflow_next;
  logic [KW_NUM-1:0] match_next;
  logic              digits_next;
  logic              ident_next;
  logic [7:0]        pend_char_next;
  logic              pend_valid_next;
  logic              in_comment_next;

  logic [7:0]        c;
  logic              c_space;
  logic              c_sep;
  logic [5:0]        pc;
  logic              slash;
  logic              active;
  logic              done;
  logic              append;
  logic              pend_v;
  logic              word_v;
  logic              newop_v;
  logic              accept;
  tok_t              pend_tok;
  tok_t              word_tok;
  tok_t              newop_tok;
  entry_t            entry;

  always_comb begin
    c = char_code;
    if (char_code == CH_TAB || char_code == CH_NUL) begin
      c = CH_SPACE;
    end
    c_space = (c == CH_SPACE);
    c_sep   = (single_code(c) != OP_NONE);
    pc      = pair_code(pend_char, c);
    slash   = pend_valid && pend_char == CH_SLASH && c == CH_SLASH;
    active  = !in_comment && !slash;
    done    = active && pend_valid && pc != OP_NONE;
    pend_v  = active && pend_valid;
    append  = active && !done && !c_space && !c_sep;

    // word state after this character is taken in
    count_next    = count;
    overflow_next = overflow;
    match_next    = match;
    digits_next   = digits;
    ident_next    = ident;
    if (append) begin
      if (count < LW'(MAX_WORD)) begin
        for (int i = 0; i < KW_NUM; i++) begin
          match_next[i] = (count == '0 || match[i]) && count < LW'(KW_MAX_LEN) &&
                          kw_byte(5'(i), count[3:0]) == c;
        end
        digits_next = (count == '0 || digits) && is_digit(c);
        if (count == '0) begin
          ident_next = (c == CH_US) || is_letter(c);
        end else begin
          ident_next = ident && ((c == CH_US) || is_digit(c) || is_letter(c));
        end
        count_next = count + LW'(1);
      end else begin
        overflow_next = 1'b1;
      end
    end

    word_v  = active && !done && (c_space || c_sep || end_of_line) && count_next != '0;
    newop_v = active && !done && c_sep && end_of_line;

    pend_tok          = '0;
    pend_tok.is_op    = 1'b1;
    pend_tok.op_code  = done ? pc : single_code(pend_char);
    pend_tok.len      = done ? LW'(2) : LW'(1);

    word_tok          = '0;
    word_tok.len      = count_next;
    word_tok.too_long = overflow_next;
    word_tok.match    = match_next;
    word_tok.digits   = digits_next;
    word_tok.ident    = ident_next;

    newop_tok         = '0;
    newop_tok.is_op   = 1'b1;
    newop_tok.op_code = single_code(c);
    newop_tok.len     = LW'(1);

    // tokens come out in the order pending operator, word, new operator
    entry = '0;
    if (pend_v) begin
      entry.t0  = pend_tok;
      entry.t1  = word_v ? word_tok : newop_tok;
      entry.two = word_v || newop_v;
    end else if (word_v) begin
      entry.t0  = word_tok;
      entry.t1  = newop_tok;
      entry.two = newop_v;
    end else begin
      entry.t0  = newop_tok;
      entry.t1  = newop_tok;
      entry.two = 1'b0;
    end

    if (word_v) begin
      count_next    = '0;
      overflow_next = 1'b0;
    end
    pend_valid_next = active && !done && c_sep && !end_of_line;
    pend_char_next  = pend_valid_next ? c : 8'h00;
    in_comment_next = in_comment ? !end_of_line : (slash && !end_of_line);

    accept  = push && !q_full;
    q_write = accept && (pend_v || word_v || newop_v);
    q_data  = entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      overflow   <= 1'b0;
      pend_char  <= 8'h00;
      pend_valid <= 1'b0;
      in_comment <= 1'b0;
    end else if (accept) begin
      count      <= count_next;
      overflow   <= overflow_next;
      pend_char  <= pend_char_next;
      pend_valid <= pend_valid_next;
      in_comment <= in_comment_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      match  <= match_next;
      digits <= digits_next;
      ident  <= ident_next;
    end
  end

endmodule

// File: hw/rtl/ctl_queue.sv
// short first-in first-out queue between the lexer front and back ends
// generic width and depth; uses ctl_pkg for the default depth
module ctl_queue import ctl_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_wr;
  logic             do_rd;

  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CW'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: hw/rtl/ctl_back.sv
// back end of the lexer: takes token records from the queue, classifies words
// and presents one token at a time in an output register; uses ctl_pkg
module ctl_back import ctl_pkg::*; #(
  parameter int MAX_WORD = DEF_MAX_WORD,
  localparam int LW = $clog2(MAX_WORD + 1),
  localparam int TOK_W = TOK_FIXED_W + LW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  logic [2*TOK_W:0] q_data,
  output logic             q_read,
  output logic             empty,
  input  logic             pop,
  output logic [2:0]       token_kind,
  output logic [5:0]       token_code,
  output logic [LW-1:0]    token_length,
  output logic             too_long,
  output logic             last_of_run
);

  typedef struct packed {
    logic              is_op;
    logic [5:0]        op_code;
    logic [LW-1:0]     len;
    logic              too_long;
    logic [KW_NUM-1:0] match;
    logic              digits;
    logic              ident;
  } tok_t;

  typedef struct packed {
    logic two;
    tok_t t1;
    tok_t t0;
  } entry_t;

  entry_t     head;
  tok_t       tok;
  logic       sel;
  logic       out_valid;
  logic       load;
  logic [2:0] kind;
  logic [5:0] code;

  always_comb begin
    head = q_data;
    tok  = sel ? head.t1 : head.t0;
    load = !q_empty && (!out_valid || pop);
    q_read = load && (sel || !head.two);

    // first keyword in table order wins
    code = OP_NONE;
    for (int i = KW_NUM - 1; i >= 0; i--) begin
      if (tok.match[i] && tok.len == LW'(KW_LEN[i]) && !tok.too_long) begin
        code = 6'(i + 1);
      end
    end
    if (tok.is_op) begin
      kind = KIND_OPERATOR;
      code = tok.op_code;
    end else if (code != OP_NONE) begin
      kind = KIND_KEYWORD;
    end else if (tok.digits) begin
      kind = KIND_NUMBER;
    end else if (tok.ident) begin
      kind = KIND_IDENT;
    end else begin
      kind = KIND_INVALID;
    end
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sel       <= !sel && head.two;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token_kind   <= kind;
      token_code   <= code;
      token_length <= tok.len;
      too_long     <= tok.too_long;
      last_of_run  <= sel || !head.two;
    end
  end

endmodule
